[hw/rtl/fbab_pkg.sv]
// Shared types, constants and the blend arithmetic for the framebuffer blend engine.
// Used by the controller, the datapath, the top level and the checker; depends on nothing else.
package fbab_pkg;

    // Frame geometry and derived widths.
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int XI_W       = $clog2(MAX_WIDTH);
    localparam int YI_W       = $clog2(MAX_HEIGHT);

    // Field widths fixed by the interface.
    localparam int COORD_W = 12;
    localparam int DIM_W   = 9;
    localparam int CH_W    = 8;
    localparam int PIX_W   = 4 * CH_W;
    localparam int IDX_W   = 2;

    localparam logic [CH_W-1:0] ALPHA_MAX = 8'hFF;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Command opcodes; the fourth code is unused and touches no pixel.
    typedef enum logic [1:0] {
        OP_PLOT  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic calc;
        logic rd;
        logic wr;
        logic init;
        logic sweep_start;
        logic sweep;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] op;
        logic       outside;
        logic       init_last;
        logic       sweep_done;
    } dp_stat_t;

    // One channel of the blend: (s*a + d*(255-a)) / 255, truncated.
    // The divide by 255 uses (v + 1 + (v >> 8)) >> 8, exact for every v the blend can form (at most 255*255).
    function automatic logic [CH_W-1:0] mix8(
        input logic [CH_W-1:0] s,
        input logic [CH_W-1:0] d,
        input logic [CH_W-1:0] a
    );
        logic [15:0] v;
        logic [16:0] t;
        v = 16'(s) * 16'(a) + 16'(d) * 16'(ALPHA_MAX - a);
        t = 17'(v) + 17'd1 + 17'(v[15:8]);
        return t[15:8];
    endfunction

    // Blend a source color into a stored pixel; alpha becomes opaque.
    function automatic logic [PIX_W-1:0] blend_pix(
        input logic [PIX_W-1:0] dst,
        input logic [CH_W-1:0]  r,
        input logic [CH_W-1:0]  g,
        input logic [CH_W-1:0]  b,
        input logic [CH_W-1:0]  a
    );
        return {ALPHA_MAX,
                mix8(b, dst[23:16], a),
                mix8(g, dst[15:8], a),
                mix8(r, dst[7:0], a)};
    endfunction

endpackage

[hw/rtl/fbab_ctrl.sv]
// Controller state machine of the framebuffer blend engine.
// Depends on fbab_pkg for the command and status structs and opcodes.
module fbab_ctrl
    import fbab_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_LOOK,
        S_MOD,
        S_SWEEP
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // Next state and commands to the datapath.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.init = 1'b1;
                if (stat.init_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.op == OP_CLEAR)
                begin
                    cmd.sweep_start = 1'b1;
                    state_next      = S_SWEEP;
                end
                else if (stat.op inside {OP_PLOT, OP_READ})
                begin
                    cmd.calc   = 1'b1;
                    state_next = S_LOOK;
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LOOK:
            begin
                if (stat.outside)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                cmd.wr     = (stat.op == OP_PLOT);
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            S_SWEEP:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[hw/rtl/fbab_dp.sv]
// Datapath of the framebuffer blend engine: frame registers, pixel memory,
// address and bounds logic, blend units and result registers. Depends on fbab_pkg.
module fbab_dp
    import fbab_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   cmd,
    output dp_stat_t                  stat,
    input  logic                      cfg_we,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [DIM_W-1:0]          cfg_data,
    input  logic [1:0]                opcode,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic [CH_W-1:0]           src_red,
    input  logic [CH_W-1:0]           src_green,
    input  logic [CH_W-1:0]           src_blue,
    input  logic [CH_W-1:0]           src_alpha,
    output logic                      done,
    output logic                      status,
    output logic [CH_W-1:0]           out_red,
    output logic [CH_W-1:0]           out_green,
    output logic [CH_W-1:0]           out_blue,
    output logic [CH_W-1:0]           out_alpha
);

    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [DIM_W-1:0]   w_eff;
    logic [DIM_W-1:0]   h_eff;
    logic [CNT_W-1:0]   count;

    logic [1:0]         op_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [CH_W-1:0]    r_reg;
    logic [CH_W-1:0]    g_reg;
    logic [CH_W-1:0]    b_reg;
    logic [CH_W-1:0]    a_reg;

    logic               in_range;
    logic [CNT_W-1:0]   addr_full;
    logic [ADDR_W-1:0]  addr_reg;
    logic               outside_reg;

    logic [CNT_W-1:0]   cnt_reg;
    logic               pend_reg;
    logic               pend_next;
    logic [ADDR_W-1:0]  pend_addr_reg;

    logic [PIX_W-1:0]   mem [DEPTH];
    logic [PIX_W-1:0]   rdata_reg;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [PIX_W-1:0]   wr_data;
    logic [PIX_W-1:0]   blended;
    logic               show_pix;

    // Frame size registers; widths above the maximum saturate on use.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(MAX_WIDTH);
            height_reg <= DIM_W'(MAX_HEIGHT);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg  <= cfg_data;
                REG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign w_eff = (width_reg > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_reg;
    assign h_eff = (height_reg > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_reg;
    assign count = CNT_W'(w_eff) * CNT_W'(h_eff);

    // Command fields are captured when the item is accepted.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= opcode;
            x_reg  <= pos_x;
            y_reg  <= pos_y;
            r_reg  <= src_red;
            g_reg  <= src_green;
            b_reg  <= src_blue;
            a_reg  <= src_alpha;
        end
    end

    // Bounds check and pixel address; the address only matters when in range.
    assign in_range = !x_reg[COORD_W-1] && !y_reg[COORD_W-1]
                   && (x_reg[COORD_W-2:0] < (COORD_W-1)'(w_eff))
                   && (y_reg[COORD_W-2:0] < (COORD_W-1)'(h_eff));
    assign addr_full = CNT_W'(y_reg[YI_W-1:0]) * CNT_W'(w_eff) + CNT_W'(x_reg[XI_W-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            addr_reg <= addr_full[ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outside_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            outside_reg <= 1'b0;
        end
        else if (cmd.calc)
        begin
            outside_reg <= !in_range;
        end
    end

    // Shared counter for the power-up clearing pass and the frame sweep.
    // During a sweep, pixel k is read while pixel k-1 is written back.
    assign pend_next = cmd.sweep && (cnt_reg < count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
            if (cmd.sweep_start)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.init || pend_next)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_next)
        begin
            pend_addr_reg <= cnt_reg[ADDR_W-1:0];
        end
    end

    // Memory port selection.
    assign blended = blend_pix(rdata_reg, r_reg, g_reg, b_reg, a_reg);
    assign rd_en   = cmd.rd || pend_next;
    assign rd_addr = cmd.rd ? addr_reg : cnt_reg[ADDR_W-1:0];
    assign wr_en   = cmd.init || cmd.wr || pend_reg;

    always_comb
    begin
        if (cmd.init)
        begin
            wr_addr = cnt_reg[ADDR_W-1:0];
            wr_data = '0;
        end
        else if (cmd.wr)
        begin
            wr_addr = addr_reg;
            wr_data = blended;
        end
        else
        begin
            wr_addr = pend_addr_reg;
            wr_data = blended;
        end
    end

    // Pixel memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Status back to the controller.
    assign stat.op         = op_reg;
    assign stat.outside    = outside_reg;
    assign stat.init_last  = (cnt_reg[ADDR_W-1:0] == {ADDR_W{1'b1}});
    assign stat.sweep_done = !pend_reg && (cnt_reg >= count);

    // Result registers; the strobe lasts one cycle.
    assign show_pix = (op_reg == OP_READ) && !outside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status    <= outside_reg;
            out_red   <= show_pix ? rdata_reg[7:0]   : '0;
            out_green <= show_pix ? rdata_reg[15:8]  : '0;
            out_blue  <= show_pix ? rdata_reg[23:16] : '0;
            out_alpha <= show_pix ? rdata_reg[31:24] : '0;
        end
    end

endmodule

[hw/rtl/framebuffer_alpha_blend_plot.sv]
// Framebuffer blend engine: one item per start pulse, one result per item, done
// for one cycle with no back-pressure. After reset the 65536-pixel memory is
// cleared one pixel a cycle, with busy high. A plot is a read-modify-write on the
// pixel memory, which has a read port and a write port: a plot or read passes the
// check, lookup and modify states before done, an out-of-frame point the check and
// lookup states, an unused opcode the check state alone, and a clear sweeps the
// frame, reading one pixel and writing the previous one each cycle. A new item is
// taken in the cycle done is shown. Depends on fbab_pkg, fbab_ctrl and fbab_dp.
module framebuffer_alpha_blend_plot
    import fbab_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                opcode,
    input  logic signed [COORD_W-1:0] pos_x,
    input  logic signed [COORD_W-1:0] pos_y,
    input  logic [CH_W-1:0]           src_red,
    input  logic [CH_W-1:0]           src_green,
    input  logic [CH_W-1:0]           src_blue,
    input  logic [CH_W-1:0]           src_alpha,
    output logic                      done,
    output logic                      status,
    output logic [CH_W-1:0]           out_red,
    output logic [CH_W-1:0]           out_green,
    output logic [CH_W-1:0]           out_blue,
    output logic [CH_W-1:0]           out_alpha,
    input  logic                      cfg_we,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [DIM_W-1:0]          cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencing of each item.
    fbab_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Storage, arithmetic and result registers.
    fbab_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .opcode    (opcode),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .src_red   (src_red),
        .src_green (src_green),
        .src_blue  (src_blue),
        .src_alpha (src_alpha),
        .done      (done),
        .status    (status),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .out_alpha (out_alpha)
    );

endmodule

[hw/rtl/fbab_checker.sv]
// Port-level checks for the framebuffer blend engine, bound to the top level.
// Depends on fbab_pkg for field widths.
module fbab_checker
    import fbab_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            start,
    input logic            busy,
    input logic            done,
    input logic            status,
    input logic [CH_W-1:0] out_red,
    input logic [CH_W-1:0] out_green,
    input logic [CH_W-1:0] out_blue,
    input logic [CH_W-1:0] out_alpha
);

    // A result strobe lasts a single cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // An accepted item makes the block busy.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // A result only appears once the block is free again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // An out-of-frame report carries no color.
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (out_red == '0 && out_green == '0
                              && out_blue == '0 && out_alpha == '0))
        else $error("out-of-frame result with nonzero color");

endmodule

bind framebuffer_alpha_blend_plot fbab_checker u_fbab_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .status    (status),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
);
